[sv/hdr_tone_mapper_rgba_unit_defines.svh]
// Assertion macros used by the checker file of the HDR tone mapper.
// Depends on nothing; the including file supplies clock and reset names.
`ifndef HDR_TONE_MAPPER_RGBA_UNIT_DEFINES_SVH
`define HDR_TONE_MAPPER_RGBA_UNIT_DEFINES_SVH

// Same-cycle implication, disabled while reset is asserted.
`define HTM_ASSERT_IMPLY(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("tone mapper check failed");

// Next-cycle implication, disabled while reset is asserted.
`define HTM_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("tone mapper check failed");

`endif

[sv/hdtm_pkg.sv]
// Package of the HDR tone mapper: widths, curve constants, register codes and beat types.
// Used by every module of the block; depends on nothing.
`timescale 1ns / 1ps

package hdtm_pkg;

	// Field widths.
	localparam int CW   = 32;
	localparam int EXPW = 24;
	localparam int OW   = 18;

	// Internal datapath widths of one lane.
	localparam int XW   = 34;
	localparam int AW   = 40;
	localparam int AH   = 20;
	localparam int PW   = 54;
	localparam int NW0  = 74;
	localparam int HALF = 37;
	localparam int KW   = 17;
	localparam int PKW  = 54;
	localparam int NW   = 108;
	localparam int DW   = 90;

	// Quotient bits produced by the divider and overall latency.
	localparam int QB       = 19;
	localparam int PREP_LAT = 6;
	localparam int LANE_LAT = PREP_LAT + QB;
	localparam int UNIT_LAT = LANE_LAT + 1;

	// White point normalization of the filmic curve, as an exact ratio.
	localparam logic [KW-1:0] WHITE_NUM = 17'd91785;
	localparam logic [KW-1:0] WHITE_DEN = 17'd66556;

	// Register indexes and reset values.
	localparam logic [0:0] REG_MODE     = 1'b0;
	localparam logic [0:0] REG_EXPOSURE = 1'b1;
	localparam logic       MODE_RESET   = 1'b0;
	localparam logic [EXPW-1:0] EXPOSURE_RESET = 24'h010000;

	typedef struct packed {
		logic            mode;
		logic [EXPW-1:0] exposure;
	} cfg_t;

	typedef struct packed {
		logic [CW-1:0] red_in;
		logic [CW-1:0] green_in;
		logic [CW-1:0] blue_in;
		logic [CW-1:0] alpha_in;
	} pixel_in_t;

	typedef struct packed {
		logic [OW-1:0] red_out;
		logic [OW-1:0] green_out;
		logic [OW-1:0] blue_out;
		logic [CW-1:0] alpha_out;
	} pixel_out_t;

endpackage

[sv/hdtm_div.sv]
// Pipelined restoring divider: one quotient bit per stage, most significant first.
// Depends on hdtm_pkg for widths and the number of quotient bits.
`timescale 1ns / 1ps

module hdtm_div (
	input  logic                   clk,
	input  logic [hdtm_pkg::NW-1:0] num,
	input  logic [hdtm_pkg::DW-1:0] den,
	output logic [hdtm_pkg::OW-1:0] quot
);
	import hdtm_pkg::*;

	logic [NW-1:0] rem_s [QB];
	logic [DW-1:0] den_s [QB];
	logic [QB-1:0] quo_s [QB];

	for (genvar k = 0; k < QB; k++) begin : g_stage
		logic [NW-1:0] rin;
		logic [DW-1:0] din;
		logic [QB-1:0] qin;
		logic [NW-1:0] trial;
		logic          fit;

		// Stage inputs come from the previous stage or the lane front end.
		if (k == 0) begin : g_first
			assign rin = num;
			assign din = den;
			assign qin = '0;
		end else begin : g_next
			assign rin = rem_s[k-1];
			assign din = den_s[k-1];
			assign qin = quo_s[k-1];
		end

		// Try to subtract the divisor aligned to this stage's quotient bit.
		always_comb begin
			trial = NW'(din) << (QB - 1 - k);
			fit   = (trial <= rin);
		end

		always_ff @(posedge clk) begin
			rem_s[k] <= fit ? (rin - trial) : rin;
			den_s[k] <= din;
			quo_s[k] <= {qin[QB-2:0], fit};
		end
	end

	assign quot = quo_s[QB-1][OW-1:0];

endmodule

[sv/hdtm_lane.sv]
// One color lane: exposure multiply, curve numerator and denominator, then division.
// Depends on hdtm_pkg and instantiates hdtm_div.
`timescale 1ns / 1ps

module hdtm_lane (
	input  logic                    clk,
	input  hdtm_pkg::cfg_t          cfg,
	input  logic [hdtm_pkg::CW-1:0] chan,
	output logic [hdtm_pkg::OW-1:0] mapped
);
	import hdtm_pkg::*;

	logic [CW+EXPW-1:0] prod_s1;
	logic [CW-1:0]      e_s2, e_s3, e_s4, e_s5;
	logic [XW-1:0]      x_s2;
	logic [AW-1:0]      a1_s2, a2_s2;
	logic [PW-1:0]      ph_s3, pl_s3, qh_s3, ql_s3;
	logic [NW0-1:0]     n0_s4, d0_s4;
	logic [PKW-1:0]     nh_s5, nl_s5, dh_s5, dl_s5;
	logic [NW-1:0]      num_s6;
	logic [DW-1:0]      den_s6;
	logic [CW-1:0]      e_c;
	logic [XW-1:0]      x_c;
	logic [NW-1:0]      num_c;
	logic [DW-1:0]      den_c;

	// Stage 1: channel times exposure, full product.
	always_ff @(posedge clk) begin
		prod_s1 <= (CW+EXPW)'(chan) * (CW+EXPW)'(cfg.exposure);
	end

	// Stage 2: saturate to Q16.16, apply the bias of two, form the linear factors.
	always_comb begin
		e_c = (prod_s1[CW+EXPW-1:CW+16] != '0) ? '1 : prod_s1[CW+15:16];
		x_c = {1'b0, e_c, 1'b0};
	end

	always_ff @(posedge clk) begin
		e_s2  <= e_c;
		x_s2  <= x_c;
		a1_s2 <= AW'(x_c) * AW'(42)  + (AW'(5)   << 16);
		a2_s2 <= AW'(x_c) * AW'(45)  + (AW'(150) << 16);
	end

	// Stage 3: quadratic products split into two partial products each.
	always_ff @(posedge clk) begin
		e_s3  <= e_s2;
		ph_s3 <= PW'(x_s2) * PW'(a1_s2[AW-1:AH]);
		pl_s3 <= PW'(x_s2) * PW'(a1_s2[AH-1:0]);
		qh_s3 <= PW'(x_s2) * PW'(a2_s2[AW-1:AH]);
		ql_s3 <= PW'(x_s2) * PW'(a2_s2[AH-1:0]);
	end

	// Stage 4: combine partials; the denominator takes its constant term.
	always_ff @(posedge clk) begin
		e_s4  <= e_s3;
		n0_s4 <= (NW0'(ph_s3) << AH) + NW0'(pl_s3);
		d0_s4 <= (NW0'(qh_s3) << AH) + NW0'(ql_s3) + (NW0'(18) << 32);
	end

	// Stage 5: white point scaling, each half times its constant.
	always_ff @(posedge clk) begin
		e_s5  <= e_s4;
		nh_s5 <= PKW'(n0_s4[NW0-1:HALF]) * PKW'(WHITE_NUM);
		nl_s5 <= PKW'(n0_s4[HALF-1:0])   * PKW'(WHITE_NUM);
		dh_s5 <= PKW'(d0_s4[NW0-1:HALF]) * PKW'(WHITE_DEN);
		dl_s5 <= PKW'(d0_s4[HALF-1:0])   * PKW'(WHITE_DEN);
	end

	// Stage 6: pick the dividend and divisor of the selected curve.
	always_comb begin
		if (cfg.mode) begin
			num_c = NW'(e_s5) << 16;
			den_c = DW'(e_s5) + DW'(65536);
		end else begin
			num_c = ((NW'(nh_s5) << HALF) + NW'(nl_s5)) << 16;
			den_c = (DW'(dh_s5) << HALF) + DW'(dl_s5);
		end
	end

	always_ff @(posedge clk) begin
		num_s6 <= num_c;
		den_s6 <= den_c;
	end

	hdtm_div u_div (
		.clk  (clk),
		.num  (num_s6),
		.den  (den_s6),
		.quot (mapped)
	);

endmodule

[sv/hdtm_merge.sv]
// Merge stage: joins the three lane results and the delayed alpha into one result beat.
// Depends on hdtm_pkg for the beat type.
`timescale 1ns / 1ps

module hdtm_merge (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    valid,
	input  logic [hdtm_pkg::OW-1:0] red,
	input  logic [hdtm_pkg::OW-1:0] green,
	input  logic [hdtm_pkg::OW-1:0] blue,
	input  logic [hdtm_pkg::CW-1:0] alpha,
	output hdtm_pkg::pixel_out_t    mapped,
	output logic                    done
);
	import hdtm_pkg::*;

	pixel_out_t beat_q;
	logic       done_q;

	// The strobe is control state and resets.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			done_q <= 1'b0;
		end else begin
			done_q <= valid;
		end
	end

	// Pack the result beat.
	always_ff @(posedge clk) begin
		beat_q.red_out   <= red;
		beat_q.green_out <= green;
		beat_q.blue_out  <= blue;
		beat_q.alpha_out <= alpha;
	end

	assign mapped = beat_q;
	assign done   = done_q;

endmodule

[sv/hdr_tone_mapper_rgba_unit.sv]
// Top level of the HDR RGBA tone mapper: register port, three color lanes, merge stage.
// Depends on hdtm_pkg, hdtm_lane and hdtm_merge.
//
//   channel   signals                              direction  beat
//   pixel     start, busy, pixel                   in         one RGBA pixel
//   result    done, mapped                         out        one mapped pixel
//   config    psel, penable, pwrite, paddr, ...    in/out     one register write/read
//
// One pixel is taken every cycle; busy never rises.
// Each result passes through 6 front-end stages in the lanes,
// 19 divider stages (one quotient bit each) and the merge register.
// Reset clears the registers to Hable mode with unit exposure and empties the pipeline.
// The receiver cannot stall; each result is shown for one cycle with done high.
`timescale 1ns / 1ps

module hdr_tone_mapper_rgba_unit (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 start,
	output logic                 busy,
	input  hdtm_pkg::pixel_in_t  pixel,
	output logic                 done,
	output hdtm_pkg::pixel_out_t mapped,
	input  logic                 psel,
	input  logic                 penable,
	input  logic                 pwrite,
	input  logic [2:0]           paddr,
	input  logic [31:0]          pwdata,
	output logic [31:0]          prdata,
	output logic                 pready
);
	import hdtm_pkg::*;

	cfg_t          cfg_q;
	logic          accept;
	logic          wr_en;
	logic [0:0]    reg_idx;
	logic          valid_s [LANE_LAT];
	logic [CW-1:0] alpha_s [LANE_LAT];
	logic [OW-1:0] red_map, green_map, blue_map;

	assign busy    = 1'b0;
	assign pready  = 1'b1;
	assign accept  = start && !busy;
	assign reg_idx = paddr[2:2];
	assign wr_en   = psel && penable && pwrite && pready;

	// Configuration registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.mode     <= MODE_RESET;
			cfg_q.exposure <= EXPOSURE_RESET;
		end else if (wr_en) begin
			case (reg_idx)
				REG_MODE:     cfg_q.mode     <= pwdata[0];
				REG_EXPOSURE: cfg_q.exposure <= pwdata[EXPW-1:0];
				default:      ;
			endcase
		end
	end

	// Register read-back.
	always_comb begin
		case (reg_idx)
			REG_MODE:     prdata = {31'b0, cfg_q.mode};
			REG_EXPOSURE: prdata = {8'b0, cfg_q.exposure};
			default:      prdata = '0;
		endcase
	end

	// Valid and alpha travel beside the lanes.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < LANE_LAT; i++) begin
				valid_s[i] <= 1'b0;
			end
		end else begin
			valid_s[0] <= accept;
			for (int i = 1; i < LANE_LAT; i++) begin
				valid_s[i] <= valid_s[i-1];
			end
		end
	end

	always_ff @(posedge clk) begin
		alpha_s[0] <= pixel.alpha_in;
		for (int i = 1; i < LANE_LAT; i++) begin
			alpha_s[i] <= alpha_s[i-1];
		end
	end

	// Three color lanes.
	hdtm_lane u_lane_red (
		.clk (clk), .cfg (cfg_q), .chan (pixel.red_in), .mapped (red_map)
	);
	hdtm_lane u_lane_green (
		.clk (clk), .cfg (cfg_q), .chan (pixel.green_in), .mapped (green_map)
	);
	hdtm_lane u_lane_blue (
		.clk (clk), .cfg (cfg_q), .chan (pixel.blue_in), .mapped (blue_map)
	);

	hdtm_merge u_merge (
		.clk    (clk),
		.arst_n (arst_n),
		.valid  (valid_s[LANE_LAT-1]),
		.red    (red_map),
		.green  (green_map),
		.blue   (blue_map),
		.alpha  (alpha_s[LANE_LAT-1]),
		.mapped (mapped),
		.done   (done)
	);

endmodule

[sv/hdtm_checker.sv]
// Port-level checker for the HDR tone mapper, bound to the top level.
// Depends on hdtm_pkg and the assertion macros header.
`timescale 1ns / 1ps
`include "hdr_tone_mapper_rgba_unit_defines.svh"

module hdtm_assertions (
	input logic                 clk,
	input logic                 arst_n,
	input logic                 start,
	input logic                 busy,
	input hdtm_pkg::pixel_in_t  pixel,
	input logic                 done,
	input hdtm_pkg::pixel_out_t mapped
);
	import hdtm_pkg::*;

	// Just above 1.3 in Q2.16; both curves stay below it.
	localparam logic [OW-1:0] CURVE_LIMIT = 18'h14CCD;

	logic in_bound;

	assign in_bound = (mapped.red_out < CURVE_LIMIT) && (mapped.green_out < CURVE_LIMIT)
		&& (mapped.blue_out < CURVE_LIMIT);

	// Every accepted pixel yields a result after the fixed latency, and only then.
	`HTM_ASSERT_IMPLY(a_result_follows, clk, arst_n, start && !busy, ##UNIT_LAT done)
	`HTM_ASSERT_IMPLY(a_no_spurious, clk, arst_n, !(start && !busy), ##UNIT_LAT !done)

	// Alpha leaves exactly as it entered.
	`HTM_ASSERT_IMPLY(a_alpha_kept, clk, arst_n, done, mapped.alpha_out == $past(pixel.alpha_in, UNIT_LAT))

	// Both curves stay below 1.3 in Q2.16.
	`HTM_ASSERT_IMPLY(a_curve_bound, clk, arst_n, done, in_bound)

endmodule

bind hdr_tone_mapper_rgba_unit hdtm_assertions u_hdtm_assertions (
	.clk    (clk),
	.arst_n (arst_n),
	.start  (start),
	.busy   (busy),
	.pixel  (pixel),
	.done   (done),
	.mapped (mapped)
);
